// ===== src/swm_pkg.sv =====
// Shared types and constants for the sliding window maximum block.
// No dependencies; imported by swm_cell and sliding_window_maximum.
package swm_pkg;

    localparam int POS_W = 16;
    localparam int CFG_W = 7;

    typedef logic [POS_W-1:0] t_pos;
    typedef logic [CFG_W-1:0] t_wsize;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic clear;  // empty the cell (final word of an array)
        logic step;   // a new word is accepted this cycle
        logic shift;  // take the right-hand neighbor's entry (oldest candidate drops)
    } t_cell_ctl;

endpackage

// ===== src/swm_cell.sv =====
// One candidate slot of the monotonic candidate chain.
// Depends on swm_pkg (t_cell_ctl, t_pos).
module swm_cell #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  swm_pkg::t_cell_ctl      i_ctl,
    input  logic [SAMPLE_WIDTH-1:0] i_new_value,
    input  swm_pkg::t_pos           i_new_pos,
    input  logic                    i_nb_valid,
    input  logic [SAMPLE_WIDTH-1:0] i_nb_value,
    input  swm_pkg::t_pos           i_nb_pos,
    input  logic                    i_prev_keep,
    output logic                    o_valid,
    output logic [SAMPLE_WIDTH-1:0] o_value,
    output swm_pkg::t_pos           o_pos,
    output logic                    o_keep
);
    import swm_pkg::*;

    logic                    r_valid;
    logic [SAMPLE_WIDTH-1:0] r_value;
    t_pos                    r_pos;
    logic                    src_valid;
    logic [SAMPLE_WIDTH-1:0] src_value;
    t_pos                    src_pos;
    logic                    keep;
    logic                    take_new;

    assign src_valid = i_ctl.shift ? i_nb_valid : r_valid;
    assign src_value = i_ctl.shift ? i_nb_value : r_value;
    assign src_pos   = i_ctl.shift ? i_nb_pos   : r_pos;

    // Survive only if strictly greater than the incoming word
    assign keep     = src_valid && ($signed(src_value) > $signed(i_new_value));
    // First slot past the survivors receives the new word
    assign take_new = !keep && i_prev_keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctl.step) begin
            r_valid <= keep || take_new;
        end else if (i_ctl.shift) begin
            r_valid <= src_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            if (keep) begin
                r_value <= src_value;
                r_pos   <= src_pos;
            end else begin
                r_value <= i_new_value;
                r_pos   <= i_new_pos;
            end
        end else if (i_ctl.shift) begin
            r_value <= src_value;
            r_pos   <= src_pos;
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_pos   = r_pos;
    assign o_keep  = keep;

endmodule

// ===== src/sliding_window_maximum.sv =====
// Sliding window maximum: top level with control, output register and cell chain.
// Depends on swm_pkg and swm_cell.
//
// Usage:
//   Input words (i_sample, i_last_of_array) arrive on i_valid / o_ready.
//   Results (o_window_max, o_last_result) leave on o_valid / i_ready.
//   Window size is written on i_cfg_valid / o_cfg_ready (always ready);
//   write it only while no word is in flight. Zero means no results.
//   The chain of MAX_WINDOW cells compares all candidates against the new
//   word in parallel, so one word per clock is sustained unless o_ready drops.
//   A result is written to the output register as its word is accepted;
//   words that complete no full window give no result.
//   After a window size write, a cleanup pass drops out-of-window candidates
//   one per cycle (0 to MAX_WINDOW of them); o_ready is low until it ends.
//   When the receiver stalls, the result holds in the output register; outside
//   cleanup, o_ready drops only while that register is full and not being taken.
//   Synchronous reset empties all cells, clears the position and fill flag,
//   and sets the window size to 3. The final word of an array clears the
//   same state after its result.
module sliding_window_maximum #(
    parameter int MAX_WINDOW   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                    i_last_of_array,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [SAMPLE_WIDTH-1:0] o_window_max,
    output logic                    o_last_result,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  swm_pkg::t_wsize         i_cfg_window_size
);
    import swm_pkg::*;

    t_wsize                  r_wsize;
    t_pos                    r_pos;
    logic                    r_filled;
    logic                    r_sweep;
    logic                    r_out_valid;
    logic [SAMPLE_WIDTH-1:0] r_out_value;
    logic                    r_out_last;

    logic [MAX_WINDOW-1:0]   c_valid;
    logic [SAMPLE_WIDTH-1:0] c_value [MAX_WINDOW];
    t_pos                    c_pos   [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]   c_keep;

    t_wsize                  w_eff;
    t_pos                    age0;
    logic                    drop0;
    logic                    sweep_drop;
    logic                    in_acc;
    logic                    cfg_acc;
    logic [POS_W:0]          pos_inc;
    logic                    filled_next;
    logic                    produce;
    logic [SAMPLE_WIDTH-1:0] src0_value;
    logic [SAMPLE_WIDTH-1:0] n_out_value;
    t_cell_ctl               ctl;

    // Clamp window size to 1..MAX_WINDOW
    always_comb begin
        if (r_wsize == '0) begin
            w_eff = CFG_W'(1);
        end else if ({{(32-CFG_W){1'b0}}, r_wsize} > 32'(MAX_WINDOW)) begin
            w_eff = CFG_W'(MAX_WINDOW);
        end else begin
            w_eff = r_wsize;
        end
    end

    assign age0       = r_pos - c_pos[0];
    assign drop0      = c_valid[0] && (age0 >= {{(POS_W-CFG_W){1'b0}}, w_eff});
    assign sweep_drop = r_sweep && drop0;

    assign o_ready     = !r_sweep && (!r_out_valid || i_ready);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_valid && o_ready;
    assign cfg_acc     = i_cfg_valid;

    assign pos_inc     = {1'b0, r_pos} + (POS_W+1)'(1);
    assign filled_next = r_filled || (pos_inc >= {{(POS_W+1-CFG_W){1'b0}}, w_eff});
    assign produce     = (r_wsize != '0) && filled_next;

    assign ctl.clear = in_acc && i_last_of_array;
    assign ctl.step  = in_acc;
    assign ctl.shift = sweep_drop || (in_acc && drop0);

    // Oldest surviving candidate after this word is the maximum
    assign src0_value  = ctl.shift ? c_value[1] : c_value[0];
    assign n_out_value = c_keep[0] ? src0_value : i_sample;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
            logic                    nb_valid;
            logic [SAMPLE_WIDTH-1:0] nb_value;
            t_pos                    nb_pos;
            logic                    prev_keep;
            logic [SAMPLE_WIDTH-1:0] cell_value;
            t_pos                    cell_pos;

            if (gi < MAX_WINDOW - 1) begin : g_mid
                assign nb_valid = c_valid[gi+1];
                assign nb_value = c_value[gi+1];
                assign nb_pos   = c_pos[gi+1];
            end else begin : g_end
                assign nb_valid = 1'b0;
                assign nb_value = '0;
                assign nb_pos   = '0;
            end

            if (gi == 0) begin : g_head
                assign prev_keep = 1'b1;
            end else begin : g_body
                assign prev_keep = c_keep[gi-1];
            end

            swm_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (ctl),
                .i_new_value (i_sample),
                .i_new_pos   (r_pos),
                .i_nb_valid  (nb_valid),
                .i_nb_value  (nb_value),
                .i_nb_pos    (nb_pos),
                .i_prev_keep (prev_keep),
                .o_valid     (c_valid[gi]),
                .o_value     (cell_value),
                .o_pos       (cell_pos),
                .o_keep      (c_keep[gi])
            );

            assign c_value[gi] = cell_value;
            assign c_pos[gi]   = cell_pos;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsize     <= CFG_W'(3);
            r_pos       <= '0;
            r_filled    <= 1'b0;
            r_sweep     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_acc) begin
                r_wsize <= i_cfg_window_size;
                r_sweep <= 1'b1;
            end else if (r_sweep && !drop0) begin
                r_sweep <= 1'b0;
            end

            if (in_acc) begin
                if (i_last_of_array) begin
                    r_pos    <= '0;
                    r_filled <= 1'b0;
                end else begin
                    r_pos    <= pos_inc[POS_W-1:0];
                    r_filled <= filled_next;
                end
            end

            if (in_acc && produce) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && produce) begin
            r_out_value <= n_out_value;
            r_out_last  <= i_last_of_array;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_window_max  = r_out_value;
    assign o_last_result = r_out_last;

`ifndef SYNTHESIS
    // Valid cells always form a prefix starting at cell 0
    a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((c_valid + MAX_WINDOW'(1)) & c_valid) == '0)
        else $error("candidate valid bits are not a prefix");

    // Final word of an array leaves the chain empty
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last_of_array) |=> (c_valid == '0))
        else $error("chain not empty after final word");

    // Outside cleanup, the chain never holds more than a window of candidates
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sweep |-> ($countones(c_valid) <= int'(w_eff)))
        else $error("more candidates than window size");

    // No word is taken during cleanup
    a_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sweep |-> !o_ready)
        else $error("input ready during cleanup");

    // A stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_window_max)))
        else $error("stalled result changed");
`endif

endmodule
